// File: rtl/core/rcd_pkg.sv
// Package for the grid DDA column raycaster.
// Holds field widths, fixed-point widths, register indexes, and the
// command and status types shared by the controller and the datapath.
package rcd_pkg;

  localparam int MAP_W_DEF    = 64;
  localparam int MAP_H_DEF    = 64;
  localparam int TEX_SIZE_DEF = 64;

  localparam int POS_W      = 24;
  localparam int DIR_W      = 18;
  localparam int SCR_W      = 13;
  localparam int COL_W      = 12;
  localparam int TIDX_W     = 6;
  localparam int TILE_W     = 8;
  localparam int HIT_W      = 8;
  localparam int PD_W       = 24;
  localparam int LH_W       = 16;
  localparam int ROW_W      = 12;
  localparam int TEXC_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int CAM_W   = 31;
  localparam int RD_W    = 32;
  localparam int DELTA_W = 33;
  localparam int SD_W    = 44;
  localparam int CELL_W  = 10;

  localparam int DIV_NW = 33;
  localparam int DIV_DW = 44;

  localparam int MUL_AW = 33;
  localparam int MUL_BW = 34;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CAST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_POS_X     = 3'd0,
    CFG_CAM_POS_Y     = 3'd1,
    CFG_VIEW_DIR_X    = 3'd2,
    CFG_VIEW_DIR_Y    = 3'd3,
    CFG_CAM_PLANE_X   = 3'd4,
    CFG_CAM_PLANE_Y   = 3'd5,
    CFG_SCREEN_WIDTH  = 3'd6,
    CFG_SCREEN_HEIGHT = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CLEAR,
    OP_DIV_CAM, OP_SET_CAM,
    OP_MUL_X, OP_RDX, OP_MUL_Y, OP_RDY,
    OP_DIV_DX, OP_SET_DX, OP_DIV_DY, OP_SET_DY,
    OP_MUL_SDX, OP_SDX, OP_MUL_SDY, OP_SDY,
    OP_STEP, OP_CHECK, OP_DIST,
    OP_DIV_LH, OP_SET_LH, OP_MUL_WALL, OP_TEX, OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_DIV_CAM, S_SET_CAM,
    S_MUL_X, S_RDX, S_MUL_Y, S_RDY,
    S_DIV_DX, S_SET_DX, S_DIV_DY, S_SET_DY,
    S_MUL_SDX, S_SDX, S_MUL_SDY, S_SDY,
    S_STEP, S_CHECK, S_DIST,
    S_DIV_LH, S_SET_LH, S_MUL_WALL, S_TEX, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/core/rcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the tile map; depends on nothing else.
module rcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/rcd_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on rcd_pkg for the numerator and divisor widths.
module rcd_div import rcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_NW-1:0] num_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      num_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
      num_r <= {num_r[DIV_NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// File: rtl/core/rcd_dp.sv
// Datapath of the raycaster: configuration registers, tile map, shared
// multiplier and divider, DDA walk registers and the output register.
// Depends on rcd_pkg, rcd_ram and rcd_div; driven by rcd_ctrl commands.
module rcd_dp import rcd_pkg::*; #(
  parameter int MAP_W    = MAP_W_DEF,
  parameter int MAP_H    = MAP_H_DEF,
  parameter int TEX_SIZE = TEX_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_fire,
  input  logic                  in_req_type,
  input  logic [COL_W-1:0]      in_column,
  input  logic [TIDX_W-1:0]     in_tile_x,
  input  logic [TIDX_W-1:0]     in_tile_y,
  input  logic [TILE_W-1:0]     in_tile_value,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [HIT_W-1:0]      out_hit_x,
  output logic [HIT_W-1:0]      out_hit_y,
  output logic [TILE_W-1:0]     out_hit_tile,
  output logic                  out_hit_side,
  output logic [PD_W-1:0]       out_perp_dist,
  output logic [LH_W-1:0]       out_line_height,
  output logic [ROW_W-1:0]      out_draw_start,
  output logic [ROW_W-1:0]      out_draw_end,
  output logic [TEXC_W-1:0]     out_tex_column
);

  localparam int CELLS  = MAP_W * MAP_H;
  localparam int ADDR_W = $clog2(CELLS);

  logic [POS_W-1:0]        cam_pos_x_r, cam_pos_y_r;
  logic signed [DIR_W-1:0] view_dir_x_r, view_dir_y_r;
  logic signed [DIR_W-1:0] cam_plane_x_r, cam_plane_y_r;
  logic [SCR_W-1:0]        scr_w_r, scr_h_r;

  logic [COL_W-1:0]         col_r;
  logic signed [CAM_W-1:0]  cam_r;
  logic signed [RD_W-1:0]   rdx_r, rdy_r;
  logic [DELTA_W-1:0]       dx_r, dy_r;
  logic [SD_W-1:0]          sdx_r, sdy_r, dist_r;
  logic signed [CELL_W-1:0] mx_r, my_r;
  logic                     side_r;
  logic                     inmap_r;
  logic [TILE_W-1:0]        tile_r;
  logic [LH_W-1:0]          lh_r;
  logic [TEXC_W-1:0]        tex_r;
  logic signed [MUL_PW-1:0] mul_r;
  logic [ADDR_W-1:0]        clr_addr_r;
  logic                     out_valid_r;

  logic [SCR_W-1:0]         w_eff, h_even, h_eff;
  logic                     rdx_neg, rdy_neg;
  logic [RD_W-1:0]          rdx_abs, rdy_abs;
  logic [16:0]              fx_sel, fy_sel;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic                     div_start;
  logic [DIV_NW-1:0]        div_num, div_quo;
  logic [DIV_DW-1:0]        div_den;
  logic                     div_done;
  logic                     step_x;
  logic signed [CELL_W-1:0] nx, ny;
  logic                     nx_in, ny_in;
  logic                     wr_in;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [TILE_W-1:0]        ram_wdata, ram_rdata;
  logic [15:0]              frac;
  logic [24:0]              tex_prod;
  logic [8:0]               tex_idx, tex_fin;
  logic                     mirror;
  logic [11:0]              half;
  logic [14:0]              lh_half;
  logic signed [16:0]       ds_full;
  logic [16:0]              de_full;
  logic [ROW_W-1:0]         ds_val, de_val;
  logic                     out_load;

  assign w_eff   = (scr_w_r == '0) ? SCR_W'(1) : scr_w_r;
  assign h_even  = {scr_h_r[SCR_W-1:1], 1'b0};
  assign h_eff   = (h_even < SCR_W'(2)) ? SCR_W'(2) :
                   (h_even > SCR_W'(4096)) ? SCR_W'(4096) : h_even;
  assign rdx_neg = rdx_r[RD_W-1];
  assign rdy_neg = rdy_r[RD_W-1];
  assign rdx_abs = rdx_neg ? RD_W'(-rdx_r) : RD_W'(rdx_r);
  assign rdy_abs = rdy_neg ? RD_W'(-rdy_r) : RD_W'(rdy_r);
  assign fx_sel  = rdx_neg ? {1'b0, cam_pos_x_r[15:0]} : 17'h10000 - {1'b0, cam_pos_x_r[15:0]};
  assign fy_sel  = rdy_neg ? {1'b0, cam_pos_y_r[15:0]} : 17'h10000 - {1'b0, cam_pos_y_r[15:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_pos_x_r   <= '0;
      cam_pos_y_r   <= '0;
      view_dir_x_r  <= '0;
      view_dir_y_r  <= '0;
      cam_plane_x_r <= '0;
      cam_plane_y_r <= '0;
      scr_w_r       <= SCR_W'(800);
      scr_h_r       <= SCR_W'(600);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CAM_POS_X:     cam_pos_x_r   <= cfg_data[POS_W-1:0];
        CFG_CAM_POS_Y:     cam_pos_y_r   <= cfg_data[POS_W-1:0];
        CFG_VIEW_DIR_X:    view_dir_x_r  <= cfg_data[DIR_W-1:0];
        CFG_VIEW_DIR_Y:    view_dir_y_r  <= cfg_data[DIR_W-1:0];
        CFG_CAM_PLANE_X:   cam_plane_x_r <= cfg_data[DIR_W-1:0];
        CFG_CAM_PLANE_Y:   cam_plane_y_r <= cfg_data[DIR_W-1:0];
        CFG_SCREEN_WIDTH:  scr_w_r       <= cfg_data[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: scr_h_r       <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_DIV_CAM: begin
        div_start = 1'b1;
        div_num   = DIV_NW'({col_r, 17'b0});
        div_den   = DIV_DW'(w_eff);
      end
      OP_DIV_DX: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(64'h1_0000_0000);
        div_den   = DIV_DW'(rdx_abs);
      end
      OP_DIV_DY: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(64'h1_0000_0000);
        div_den   = DIV_DW'(rdy_abs);
      end
      OP_DIV_LH: begin
        div_start = 1'b1;
        div_num   = DIV_NW'({h_eff, 16'b0});
        div_den   = dist_r;
      end
      default: ;
    endcase
  end

  rcd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_X: begin
        mul_a = MUL_AW'(cam_plane_x_r);
        mul_b = MUL_BW'(cam_r);
      end
      OP_MUL_Y: begin
        mul_a = MUL_AW'(cam_plane_y_r);
        mul_b = MUL_BW'(cam_r);
      end
      OP_MUL_SDX: begin
        mul_a = MUL_AW'(fx_sel);
        mul_b = MUL_BW'(dx_r);
      end
      OP_MUL_SDY: begin
        mul_a = MUL_AW'(fy_sel);
        mul_b = MUL_BW'(dy_r);
      end
      OP_MUL_WALL: begin
        mul_a = MUL_AW'(dist_r[31:0]);
        mul_b = side_r ? MUL_BW'(rdx_r[31:0]) : MUL_BW'(rdy_r[31:0]);
      end
      default: ;
    endcase
  end

  assign step_x = sdx_r < sdy_r;
  assign nx     = step_x ? (rdx_neg ? mx_r - CELL_W'(1) : mx_r + CELL_W'(1)) : mx_r;
  assign ny     = step_x ? my_r : (rdy_neg ? my_r - CELL_W'(1) : my_r + CELL_W'(1));
  assign nx_in  = (int'(nx) >= 0) && (int'(nx) < MAP_W);
  assign ny_in  = (int'(ny) >= 0) && (int'(ny) < MAP_H);
  assign ram_raddr = (nx_in && ny_in) ?
                     ADDR_W'(nx[7:0]) + ADDR_W'(ny[7:0]) * ADDR_W'(MAP_W) : '0;

  assign wr_in = (int'(in_tile_x) < MAP_W) && (int'(in_tile_y) < MAP_H);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd.op == OP_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
    end else if (in_fire && in_req_type == REQ_LOAD && wr_in) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(in_tile_x) + ADDR_W'(in_tile_y) * ADDR_W'(MAP_W);
      ram_wdata = in_tile_value;
    end
  end

  rcd_ram #(
    .WIDTH (TILE_W),
    .DEPTH (CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign frac     = side_r ? cam_pos_x_r[15:0] + 16'(mul_r[31:16])
                           : cam_pos_y_r[15:0] + 16'(mul_r[31:16]);
  assign tex_prod = 25'(frac) * 25'(TEX_SIZE);
  assign tex_idx  = tex_prod[24:16];
  assign mirror   = (!side_r && !rdx_neg && rdx_r != '0) || (side_r && rdy_neg);
  assign tex_fin  = mirror ? 9'(TEX_SIZE - 1) - tex_idx : tex_idx;

  assign half    = h_eff[12:1];
  assign lh_half = lh_r[15:1];
  assign ds_full = $signed({5'b0, half}) - $signed({2'b0, lh_half});
  assign ds_val  = ds_full[16] ? '0 : ds_full[ROW_W-1:0];
  assign de_full = 17'(lh_half) + 17'(half);
  assign de_val  = (de_full + 17'd1 >= 17'(h_eff)) ? ROW_W'(h_eff - SCR_W'(2))
                                                    : de_full[ROW_W-1:0];

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_load      = (cmd.op == OP_OUT) && stat.out_free;
  assign stat.div_done = div_done;
  assign stat.clr_last = clr_addr_r == ADDR_W'(CELLS - 1);
  assign stat.hit      = inmap_r ? (ram_rdata != '0) : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_req_type == REQ_CAST) begin
      col_r <= in_column;
      mx_r  <= $signed({2'b0, cam_pos_x_r[23:16]});
      my_r  <= $signed({2'b0, cam_pos_y_r[23:16]});
    end
    case (cmd.op)
      OP_SET_CAM: cam_r <= $signed(div_quo[CAM_W-1:0]) - CAM_W'(65536);
      OP_MUL_X, OP_MUL_Y, OP_MUL_SDX, OP_MUL_SDY, OP_MUL_WALL: mul_r <= mul_a * mul_b;
      OP_RDX: rdx_r <= RD_W'(view_dir_x_r) + RD_W'(mul_r >>> 16);
      OP_RDY: rdy_r <= RD_W'(view_dir_y_r) + RD_W'(mul_r >>> 16);
      OP_SET_DX: dx_r <= (rdx_r == '0) ? DELTA_W'(64'h1_0000_0000) : div_quo;
      OP_SET_DY: dy_r <= (rdy_r == '0) ? DELTA_W'(64'h1_0000_0000) : div_quo;
      OP_SDX: sdx_r <= mul_r[16 +: SD_W];
      OP_SDY: sdy_r <= mul_r[16 +: SD_W];
      OP_STEP: begin
        if (step_x) begin
          sdx_r  <= sdx_r + SD_W'(dx_r);
          side_r <= 1'b0;
        end else begin
          sdy_r  <= sdy_r + SD_W'(dy_r);
          side_r <= 1'b1;
        end
        mx_r    <= nx;
        my_r    <= ny;
        inmap_r <= nx_in && ny_in;
      end
      OP_CHECK: tile_r <= inmap_r ? ram_rdata : TILE_W'(1);
      OP_DIST: dist_r <= side_r ? sdy_r - SD_W'(dy_r) : sdx_r - SD_W'(dx_r);
      OP_SET_LH: begin
        if (dist_r == '0 || div_quo > DIV_NW'(65535)) begin
          lh_r <= LH_W'(65535);
        end else begin
          lh_r <= div_quo[LH_W-1:0];
        end
      end
      OP_TEX: tex_r <= tex_fin[TEXC_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_x       <= mx_r[HIT_W-1:0];
      out_hit_y       <= my_r[HIT_W-1:0];
      out_hit_tile    <= tile_r;
      out_hit_side    <= side_r;
      out_perp_dist   <= (dist_r > SD_W'(24'hFFFFFF)) ? 24'hFFFFFF : dist_r[PD_W-1:0];
      out_line_height <= lh_r;
      out_draw_start  <= ds_val;
      out_draw_end    <= de_val;
      out_tex_column  <= tex_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/rcd_ctrl.sv
// Controller state machine of the raycaster: map clearing, item accept,
// and the sequence of datapath operations for one cast. Depends on rcd_pkg.
module rcd_ctrl import rcd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_type,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid && in_req_type == REQ_CAST) state_nxt = S_DIV_CAM;
      S_DIV_CAM:  state_nxt = S_SET_CAM;
      S_SET_CAM:  if (stat.div_done) state_nxt = S_MUL_X;
      S_MUL_X:    state_nxt = S_RDX;
      S_RDX:      state_nxt = S_MUL_Y;
      S_MUL_Y:    state_nxt = S_RDY;
      S_RDY:      state_nxt = S_DIV_DX;
      S_DIV_DX:   state_nxt = S_SET_DX;
      S_SET_DX:   if (stat.div_done) state_nxt = S_DIV_DY;
      S_DIV_DY:   state_nxt = S_SET_DY;
      S_SET_DY:   if (stat.div_done) state_nxt = S_MUL_SDX;
      S_MUL_SDX:  state_nxt = S_SDX;
      S_SDX:      state_nxt = S_MUL_SDY;
      S_MUL_SDY:  state_nxt = S_SDY;
      S_SDY:      state_nxt = S_STEP;
      S_STEP:     state_nxt = S_CHECK;
      S_CHECK:    state_nxt = stat.hit ? S_DIST : S_STEP;
      S_DIST:     state_nxt = S_DIV_LH;
      S_DIV_LH:   state_nxt = S_SET_LH;
      S_SET_LH:   if (stat.div_done) state_nxt = S_MUL_WALL;
      S_MUL_WALL: state_nxt = S_TEX;
      S_TEX:      state_nxt = S_OUT;
      S_OUT:      if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.op       = OP_IDLE;
    case (state_r)
      S_CLEAR:    cmd.op = OP_CLEAR;
      S_IDLE:     cmd.in_ready = 1'b1;
      S_DIV_CAM:  cmd.op = OP_DIV_CAM;
      S_SET_CAM:  cmd.op = OP_SET_CAM;
      S_MUL_X:    cmd.op = OP_MUL_X;
      S_RDX:      cmd.op = OP_RDX;
      S_MUL_Y:    cmd.op = OP_MUL_Y;
      S_RDY:      cmd.op = OP_RDY;
      S_DIV_DX:   cmd.op = OP_DIV_DX;
      S_SET_DX:   cmd.op = OP_SET_DX;
      S_DIV_DY:   cmd.op = OP_DIV_DY;
      S_SET_DY:   cmd.op = OP_SET_DY;
      S_MUL_SDX:  cmd.op = OP_MUL_SDX;
      S_SDX:      cmd.op = OP_SDX;
      S_MUL_SDY:  cmd.op = OP_MUL_SDY;
      S_SDY:      cmd.op = OP_SDY;
      S_STEP:     cmd.op = OP_STEP;
      S_CHECK:    cmd.op = OP_CHECK;
      S_DIST:     cmd.op = OP_DIST;
      S_DIV_LH:   cmd.op = OP_DIV_LH;
      S_SET_LH:   cmd.op = OP_SET_LH;
      S_MUL_WALL: cmd.op = OP_MUL_WALL;
      S_TEX:      cmd.op = OP_TEX;
      S_OUT:      cmd.op = OP_OUT;
      default:    cmd.op = OP_IDLE;
    endcase
  end

endmodule

// File: rtl/core/grid_dda_column_raycaster_top.sv
// A cast runs four serial divisions in the shared divider, a series of
// multiply and update steps, and a step and a check state for each cell
// walked, the check taking the map RAM's registered read. One item is in
// work at a time.
// After reset the map RAM is cleared one cell a cycle, all MAP_W*MAP_H cells
// (4096 by default), with in_ready low; configuration writes are taken.
module grid_dda_column_raycaster_top import rcd_pkg::*; #(
  parameter int MAP_W    = MAP_W_DEF,
  parameter int MAP_H    = MAP_H_DEF,
  parameter int TEX_SIZE = TEX_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [COL_W-1:0]      in_column,
  input  logic [TIDX_W-1:0]     in_tile_x,
  input  logic [TIDX_W-1:0]     in_tile_y,
  input  logic [TILE_W-1:0]     in_tile_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [HIT_W-1:0]      out_hit_x,
  output logic [HIT_W-1:0]      out_hit_y,
  output logic [TILE_W-1:0]     out_hit_tile,
  output logic                  out_hit_side,
  output logic [PD_W-1:0]       out_perp_dist,
  output logic [LH_W-1:0]       out_line_height,
  output logic [ROW_W-1:0]      out_draw_start,
  output logic [ROW_W-1:0]      out_draw_end,
  output logic [TEXC_W-1:0]     out_tex_column
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire;

  assign in_ready = cmd.in_ready;
  assign in_fire  = in_valid && cmd.in_ready;

  rcd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd)
  );

  rcd_dp #(
    .MAP_W    (MAP_W),
    .MAP_H    (MAP_H),
    .TEX_SIZE (TEX_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_fire         (in_fire),
    .in_req_type     (in_req_type),
    .in_column       (in_column),
    .in_tile_x       (in_tile_x),
    .in_tile_y       (in_tile_y),
    .in_tile_value   (in_tile_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit_x       (out_hit_x),
    .out_hit_y       (out_hit_y),
    .out_hit_tile    (out_hit_tile),
    .out_hit_side    (out_hit_side),
    .out_perp_dist   (out_perp_dist),
    .out_line_height (out_line_height),
    .out_draw_start  (out_draw_start),
    .out_draw_end    (out_draw_end),
    .out_tex_column  (out_tex_column)
  );

endmodule

// File: rtl/core/rcd_chk.sv
// Port-level checker for the raycaster top level, attached by bind.
// Depends on rcd_pkg and on the port list of grid_dda_column_raycaster_top.
module rcd_chk import rcd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_req_type,
  input logic [COL_W-1:0]      in_column,
  input logic [TIDX_W-1:0]     in_tile_x,
  input logic [TIDX_W-1:0]     in_tile_y,
  input logic [TILE_W-1:0]     in_tile_value,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [HIT_W-1:0]      out_hit_x,
  input logic [HIT_W-1:0]      out_hit_y,
  input logic [TILE_W-1:0]     out_hit_tile,
  input logic                  out_hit_side,
  input logic [PD_W-1:0]       out_perp_dist,
  input logic [LH_W-1:0]       out_line_height,
  input logic [ROW_W-1:0]      out_draw_start,
  input logic [ROW_W-1:0]      out_draw_end,
  input logic [TEXC_W-1:0]     out_tex_column
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_perp_dist) && $stable(out_hit_x))
    else $error("result transaction changed while stalled");

  a_hit_tile: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_tile != '0)
    else $error("result reports an empty tile as hit");

  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_CAST |=> !in_ready)
    else $error("cast transaction did not occupy the block");

  a_start_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_draw_start <= ROW_W'(2048))
    else $error("draw start beyond half of the tallest screen");

endmodule

bind grid_dda_column_raycaster_top rcd_chk u_rcd_chk (.*);
